### rtl/ccm_sfe_pkg.sv
// Shared types, constants and AES helper functions for the secured frame encoder.
`default_nettype none
package ccm_sfe_pkg;

    localparam int MAX_BODY    = 128;
    localparam int NONCE_BYTES = 13;
    localparam int TAG_BYTES   = 4;
    localparam int LEN_BYTES   = 15 - NONCE_BYTES;

    localparam logic [7:0] B0_FLAGS = 8'(64 | (((TAG_BYTES - 2) / 2) << 3) | (LEN_BYTES - 1));
    localparam logic [7:0] A_FLAGS  = 8'(LEN_BYTES - 1);

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_BUF_SIZE = 2'd2;
    localparam logic [7:0] BUF_SIZE_RESET = 8'd255;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LONG = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_BODY   = 2'd1,
        CMD_REJECT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic        func;
        logic        version;
        logic [2:0]  msg_type;
        logic [7:0]  source;
        logic [7:0]  destination;
        logic [31:0] counter;
        logic [3:0]  budget;
        logic [7:0]  body_length;
        logic [7:0]  body_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } out_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  ctrl;
        logic [7:0]  source;
        logic [7:0]  destination;
        logic [31:0] counter;
        logic        wide;
        logic [3:0]  budget;
        logic [7:0]  body_length;
        logic [7:0]  body_byte;
        logic        last;
        logic [1:0]  status;
    } cmd_t;

    localparam logic [2047:0] SBOX_TBL = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        sbox = SBOX_TBL[{~x, 3'b111} -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] v);
        xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = {sbox(rk[23:16]) ^ rc, sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
        w0 = rk[127:96] ^ t;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        key_next = {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
                                               input logic final_rnd);
        logic [7:0] s [16];
        logic [7:0] b [16];
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        logic [7:0] al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            s[i] = sbox(st[127 - 8 * i -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                b[j + 4 * c] = s[j + 4 * ((c + j) % 4)];
            end
        end
        if (!final_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = b[4 * c];
                a1 = b[4 * c + 1];
                a2 = b[4 * c + 2];
                a3 = b[4 * c + 3];
                al = a0 ^ a1 ^ a2 ^ a3;
                b[4 * c]     = a0 ^ al ^ xt(a0 ^ a1);
                b[4 * c + 1] = a1 ^ al ^ xt(a1 ^ a2);
                b[4 * c + 2] = a2 ^ al ^ xt(a2 ^ a3);
                b[4 * c + 3] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = b[i];
        end
        aes_round = r ^ rk;
    endfunction

    // flags, nonce (ctrl, src, dst, 32-bit counter, zero pad), length/index field
    function automatic logic [127:0] make_block(input logic [7:0] flags, input logic [7:0] ctrl,
                                                input logic [7:0] src, input logic [7:0] dst,
                                                input logic [31:0] cnt, input logic [7:0] tail);
        make_block = {flags, ctrl, src, dst, cnt, 56'd0, tail};
    endfunction

endpackage
`default_nettype wire

### rtl/ccm_secured_frame_encoder_unit.sv
// Top level of the AES-128-CCM secured frame encoder.
// A header item yields the frame header (6 or 7 bytes) after three AES passes (B0,
// additional data, tag mask), then one header byte per cycle while the result queue has
// room. The first body byte of every 16-byte block adds a keystream pass, and the 16th
// byte or the last one adds a CBC-MAC pass. The frame ends with 4 tag bytes and a
// trailer byte. All AES passes run on the single shared round-iterative AES unit. A
// 4-entry command queue lets the input side run ahead; a 4-entry result queue decouples
// the output side. Rejected frames give one result with last set and a nonzero status;
// their body items are absorbed silently.
`default_nettype none
module ccm_secured_frame_encoder_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ccm_sfe_pkg::in_t  item,
    output logic                   full,
    output logic                   empty,
    input  wire logic              pop,
    output ccm_sfe_pkg::out_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_data
);

    logic [63:0]       key_high_reg, key_high_next;
    logic [63:0]       key_low_reg, key_low_next;
    logic [7:0]        buf_size_reg, buf_size_next;
    logic              cfg_wr;
    logic              cmd_valid;
    logic              cmd_pop;
    ccm_sfe_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_comb
    begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        buf_size_next = buf_size_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                ccm_sfe_pkg::REG_KEY_HIGH: key_high_next = cfg_data;
                ccm_sfe_pkg::REG_KEY_LOW:  key_low_next  = cfg_data;
                ccm_sfe_pkg::REG_BUF_SIZE: buf_size_next = cfg_data[7:0];
                default:                   buf_size_next = buf_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= 64'd0;
            key_low_reg  <= 64'd0;
            buf_size_reg <= ccm_sfe_pkg::BUF_SIZE_RESET;
        end
        else
        begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
            buf_size_reg <= buf_size_next;
        end
    end

    ccm_sfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .buf_size  (buf_size_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ccm_sfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_high_reg, key_low_reg}),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // rejection results always close the transaction stream of their frame
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != ccm_sfe_pkg::ST_OK) |-> result.last)
        else $error("rejection without last");

    // header, ciphertext and tag bytes never carry an error status
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.last) |-> (result.status == ccm_sfe_pkg::ST_OK))
        else $error("error status on a mid-frame byte");

    // the back end only takes commands that the queue holds
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

endmodule
`default_nettype wire

### rtl/ccm_sfe_aes.sv
// Round-iterative AES-128 encryption unit, one round per cycle.
`default_nettype none
module ccm_sfe_aes (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] din,
    input  wire logic [127:0] key,
    output logic              done,
    output logic [127:0]      dout
);

    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rc_reg, rc_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [127:0] rk_adv;

    always_comb
    begin
        rk_adv    = ccm_sfe_pkg::key_next(rk_reg, rc_reg);
        st_next   = st_reg;
        rk_next   = rk_reg;
        rc_next   = rc_reg;
        rnd_next  = rnd_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            st_next   = din ^ key;
            rk_next   = key;
            rc_next   = 8'h01;
            rnd_next  = 4'd1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            st_next  = ccm_sfe_pkg::aes_round(st_reg, rk_adv, rnd_reg == 4'd10);
            rk_next  = rk_adv;
            rc_next  = ccm_sfe_pkg::xt(rc_reg);
            rnd_next = rnd_reg + 4'd1;
            if (rnd_reg == 4'd10)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg   <= 8'h01;
            rnd_reg  <= 4'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rc_reg   <= rc_next;
            rnd_reg  <= rnd_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        rk_reg <= rk_next;
    end

    assign done = done_reg;
    assign dout = st_reg;

endmodule
`default_nettype wire

### rtl/ccm_sfe_front.sv
// Front end: accepts items, tracks frame state, checks limits and queues commands.
`default_nettype none
module ccm_sfe_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ccm_sfe_pkg::in_t  item,
    output logic                   full,
    input  wire logic [7:0]        buf_size,
    output logic                   cmd_valid,
    output ccm_sfe_pkg::cmd_t      cmd,
    input  wire logic              cmd_pop
);

    localparam int QD = 4;

    logic              active_reg, active_next;
    logic              drop_reg, drop_next;
    logic [7:0]        left_reg, left_next;
    ccm_sfe_pkg::cmd_t q_reg [QD];
    logic [1:0]        wr_reg, wr_next;
    logic [1:0]        rd_reg, rd_next;
    logic [2:0]        cnt_reg, cnt_next;

    logic              accept;
    logic              wide;
    logic [2:0]        hlen;
    logic [8:0]        frame_len;
    logic              too_long;
    logic              too_big;
    logic              enq;
    ccm_sfe_pkg::cmd_t c;

    assign accept = push & ~full;

    always_comb
    begin
        wide      = |item.counter[31:24];
        hlen      = wide ? 3'd7 : 3'd6;
        frame_len = 9'(hlen) + 9'(item.body_length) + 9'(ccm_sfe_pkg::TAG_BYTES + 1);
        too_long  = item.body_length > 8'(ccm_sfe_pkg::MAX_BODY);
        too_big   = frame_len > {1'b0, buf_size};

        c.kind        = ccm_sfe_pkg::CMD_BODY;
        c.ctrl        = {item.version, item.msg_type, wide, 3'b000};
        c.source      = item.source;
        c.destination = item.destination;
        c.counter     = item.counter;
        c.wide        = wide;
        c.budget      = item.budget;
        c.body_length = item.body_length;
        c.body_byte   = item.body_byte;
        c.last        = left_reg == 8'd1;
        c.status      = too_long ? ccm_sfe_pkg::ST_LONG : ccm_sfe_pkg::ST_SIZE;

        enq         = 1'b0;
        active_next = active_reg;
        drop_next   = drop_reg;
        left_next   = left_reg;

        if (accept)
        begin
            if (!item.func)
            begin
                // a new header abandons whatever frame was open
                left_next = item.body_length;
                enq       = 1'b1;
                if (too_long || too_big)
                begin
                    c.kind      = ccm_sfe_pkg::CMD_REJECT;
                    drop_next   = item.body_length != 8'd0;
                    active_next = 1'b0;
                end
                else
                begin
                    c.kind      = ccm_sfe_pkg::CMD_START;
                    drop_next   = 1'b0;
                    active_next = item.body_length != 8'd0;
                end
            end
            else if (drop_reg)
            begin
                if (left_reg != 8'd0)
                begin
                    left_next = left_reg - 8'd1;
                end
                if (left_reg <= 8'd1)
                begin
                    drop_next = 1'b0;
                end
            end
            else if (active_reg)
            begin
                enq       = 1'b1;
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    active_next = 1'b0;
                end
            end
        end

        wr_next  = enq ? wr_reg + 2'd1 : wr_reg;
        rd_next  = cmd_pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + 3'(enq) - 3'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            drop_reg   <= 1'b0;
            left_reg   <= 8'd0;
            wr_reg     <= 2'd0;
            rd_reg     <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            active_reg <= active_next;
            drop_reg   <= drop_next;
            left_reg   <= left_next;
            wr_reg     <= wr_next;
            rd_reg     <= rd_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_reg] <= c;
        end
    end

    assign full      = cnt_reg == 3'(QD);
    assign cmd_valid = cnt_reg != 3'd0;
    assign cmd       = q_reg[rd_reg];

endmodule
`default_nettype wire

### rtl/ccm_sfe_back.sv
// Back end: runs CBC-MAC and CTR on the AES unit and streams frame bytes out.
`default_nettype none
module ccm_sfe_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [127:0]      key,
    input  wire logic              cmd_valid,
    input  wire ccm_sfe_pkg::cmd_t cmd,
    output logic                   cmd_pop,
    output logic                   empty,
    input  wire logic              pop,
    output ccm_sfe_pkg::out_t      result
);

    localparam int OD = 4;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_B0    = 11'b00000000010,
        S_HMAC  = 11'b00000000100,
        S_A0    = 11'b00000001000,
        S_HDR   = 11'b00000010000,
        S_KS    = 11'b00000100000,
        S_BODY  = 11'b00001000000,
        S_MACW  = 11'b00010000000,
        S_TAG   = 11'b00100000000,
        S_TRAIL = 11'b01000000000,
        S_REJ   = 11'b10000000000
    } state_t;

    state_t            state_reg, state_next;
    ccm_sfe_pkg::cmd_t hdr_reg, hdr_next;
    ccm_sfe_pkg::cmd_t cur_reg, cur_next;
    logic [127:0]      mac_reg, mac_next;
    logic [127:0]      ks_reg, ks_next;
    logic [127:0]      tm_reg, tm_next;
    logic [7:0]        idx_reg, idx_next;
    logic [3:0]        pos_reg, pos_next;
    logic [3:0]        ecnt_reg, ecnt_next;

    ccm_sfe_pkg::out_t of_reg [OD];
    logic [1:0]        ofw_reg, ofw_next;
    logic [1:0]        ofr_reg, ofr_next;
    logic [2:0]        ofc_reg, ofc_next;
    logic              of_full;
    logic              of_push;
    logic              of_pop;
    ccm_sfe_pkg::out_t of_item;

    logic              aes_start;
    logic [127:0]      aes_din;
    logic              aes_done;
    logic [127:0]      aes_dout;

    logic [55:0]       hdr_vec;
    logic [55:0]       hdr_sh;
    logic              hdr_end;
    logic [127:0]      hx_vec;
    logic [127:0]      tag_vec;
    logic [127:0]      mac_x;
    logic [7:0]        ks_byte;

    ccm_sfe_aes u_aes (
        .clk   (clk),
        .rst_n (rst_n),
        .start (aes_start),
        .din   (aes_din),
        .key   (key),
        .done  (aes_done),
        .dout  (aes_dout)
    );

    assign of_full = ofc_reg == 3'(OD);
    assign of_pop  = pop & ~empty;

    always_comb
    begin
        hdr_vec = hdr_reg.wide ? {hdr_reg.ctrl, hdr_reg.source, hdr_reg.destination,
                                  hdr_reg.counter}
                               : {hdr_reg.ctrl, hdr_reg.source, hdr_reg.destination,
                                  hdr_reg.counter[23:0], 8'h00};
        hdr_sh  = hdr_vec << {ecnt_reg[2:0], 3'b000};
        hdr_end = ecnt_reg[2:0] == (hdr_reg.wide ? 3'd6 : 3'd5);
        // additional data block: two-byte length, then the header bytes
        hx_vec  = {8'h00, 5'd0, (hdr_reg.wide ? 3'd7 : 3'd6), hdr_vec, 56'd0};
        tag_vec = mac_reg ^ tm_reg;
        ks_byte = ks_reg[{~pos_reg, 3'b111} -: 8];
        mac_x   = mac_reg ^ ({cur_reg.body_byte, 120'd0} >> {pos_reg, 3'b000});

        state_next = state_reg;
        hdr_next   = hdr_reg;
        cur_next   = cur_reg;
        mac_next   = mac_reg;
        ks_next    = ks_reg;
        tm_next    = tm_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        ecnt_next  = ecnt_reg;
        aes_start  = 1'b0;
        aes_din    = '0;
        cmd_pop    = 1'b0;
        of_push    = 1'b0;
        of_item    = '{out_byte: 8'd0, last: 1'b0, status: ccm_sfe_pkg::ST_OK};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    case (cmd.kind)
                        ccm_sfe_pkg::CMD_START:
                        begin
                            hdr_next   = cmd;
                            idx_next   = 8'd1;
                            pos_next   = 4'd0;
                            aes_start  = 1'b1;
                            aes_din    = ccm_sfe_pkg::make_block(ccm_sfe_pkg::B0_FLAGS,
                                             cmd.ctrl, cmd.source, cmd.destination,
                                             cmd.counter, cmd.body_length);
                            state_next = S_B0;
                        end
                        ccm_sfe_pkg::CMD_BODY:
                        begin
                            if (pos_reg == 4'd0)
                            begin
                                aes_start  = 1'b1;
                                aes_din    = ccm_sfe_pkg::make_block(ccm_sfe_pkg::A_FLAGS,
                                                 hdr_reg.ctrl, hdr_reg.source,
                                                 hdr_reg.destination, hdr_reg.counter, idx_reg);
                                state_next = S_KS;
                            end
                            else
                            begin
                                state_next = S_BODY;
                            end
                        end
                        ccm_sfe_pkg::CMD_REJECT:
                        begin
                            state_next = S_REJ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_B0:
            begin
                if (aes_done)
                begin
                    aes_start  = 1'b1;
                    aes_din    = aes_dout ^ hx_vec;
                    state_next = S_HMAC;
                end
            end
            S_HMAC:
            begin
                if (aes_done)
                begin
                    mac_next   = aes_dout;
                    aes_start  = 1'b1;
                    aes_din    = ccm_sfe_pkg::make_block(ccm_sfe_pkg::A_FLAGS, hdr_reg.ctrl,
                                     hdr_reg.source, hdr_reg.destination, hdr_reg.counter, 8'd0);
                    state_next = S_A0;
                end
            end
            S_A0:
            begin
                if (aes_done)
                begin
                    tm_next    = aes_dout;
                    ecnt_next  = 4'd0;
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                if (!of_full)
                begin
                    of_push          = 1'b1;
                    of_item.out_byte = hdr_sh[55:48];
                    if (hdr_end)
                    begin
                        ecnt_next  = 4'd0;
                        state_next = (hdr_reg.body_length == 8'd0) ? S_TAG : S_IDLE;
                    end
                    else
                    begin
                        ecnt_next = ecnt_reg + 4'd1;
                    end
                end
            end
            S_KS:
            begin
                if (aes_done)
                begin
                    ks_next    = aes_dout;
                    state_next = S_BODY;
                end
            end
            S_BODY:
            begin
                if (!of_full)
                begin
                    of_push          = 1'b1;
                    of_item.out_byte = cur_reg.body_byte ^ ks_byte;
                    mac_next         = mac_x;
                    if (pos_reg == 4'd15 || cur_reg.last)
                    begin
                        aes_start  = 1'b1;
                        aes_din    = mac_x;
                        pos_next   = 4'd0;
                        idx_next   = idx_reg + 8'd1;
                        state_next = S_MACW;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 4'd1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_MACW:
            begin
                if (aes_done)
                begin
                    mac_next   = aes_dout;
                    ecnt_next  = 4'd0;
                    state_next = cur_reg.last ? S_TAG : S_IDLE;
                end
            end
            S_TAG:
            begin
                if (!of_full)
                begin
                    of_push          = 1'b1;
                    of_item.out_byte = tag_vec[{~ecnt_reg, 3'b111} -: 8];
                    if (ecnt_reg == 4'(ccm_sfe_pkg::TAG_BYTES - 1))
                    begin
                        ecnt_next  = 4'd0;
                        state_next = S_TRAIL;
                    end
                    else
                    begin
                        ecnt_next = ecnt_reg + 4'd1;
                    end
                end
            end
            S_TRAIL:
            begin
                if (!of_full)
                begin
                    of_push          = 1'b1;
                    of_item.out_byte = {hdr_reg.budget, 4'h0};
                    of_item.last     = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_REJ:
            begin
                if (!of_full)
                begin
                    of_push        = 1'b1;
                    of_item.last   = 1'b1;
                    of_item.status = cur_reg.status;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ofw_next = of_push ? ofw_reg + 2'd1 : ofw_reg;
        ofr_next = of_pop ? ofr_reg + 2'd1 : ofr_reg;
        ofc_next = ofc_reg + 3'(of_push) - 3'(of_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mac_reg   <= '0;
            ks_reg    <= '0;
            tm_reg    <= '0;
            idx_reg   <= 8'd0;
            pos_reg   <= 4'd0;
            ecnt_reg  <= 4'd0;
            ofw_reg   <= 2'd0;
            ofr_reg   <= 2'd0;
            ofc_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            mac_reg   <= mac_next;
            ks_reg    <= ks_next;
            tm_reg    <= tm_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            ecnt_reg  <= ecnt_next;
            ofw_reg   <= ofw_next;
            ofr_reg   <= ofr_next;
            ofc_reg   <= ofc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        cur_reg <= cur_next;
        if (of_push)
        begin
            of_reg[ofw_reg] <= of_item;
        end
    end

    assign empty  = ofc_reg == 3'd0;
    assign result = of_reg[ofr_reg];

endmodule
`default_nettype wire

### test/tb_ccm_secured_frame_encoder_unit.sv
// Self-checking testbench for the CCM secured frame encoder with its own predictor.
`default_nettype none
module tb_ccm_secured_frame_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ccm_sfe_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    in_t         item = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    out_t        result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_KEY_HIGH;
    logic [63:0] cfg_data = '0;

    ccm_secured_frame_encoder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [63:0]  key_hi = '0;
    logic [63:0]  key_lo = '0;
    logic [7:0]   buf_limit = BUF_SIZE_RESET;
    logic [127:0] mac_acc = '0;
    logic [127:0] key_stream = '0;
    logic [127:0] tag_pad = '0;
    logic [7:0]   hdr_bytes [7];
    logic [7:0]   ctr_block = '0;
    logic [3:0]   blk_pos = '0;
    logic [7:0]   remaining = '0;
    logic [3:0]   hop_budget = '0;
    logic         frame_open = 1'b0;
    logic         discarding = 1'b0;

    in_t  frame_items [$];
    bit   wait_drain [$];
    out_t expected_bytes [$];
    int   errors = 0;
    bit   send_bursty = 1'b1;
    bit   recv_bursty = 1'b1;
    int   send_gap = 0;
    int   recv_gap = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        return SBOX_TBL[2047 - 8 * x -: 8];
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
        logic [7:0]   rk [176];
        logic [7:0]   t [4];
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   f;
        logic [7:0]   rc;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        logic [7:0]   al;
        logic [127:0] kk;
        logic [127:0] ct;
        kk = {key_hi, key_lo};
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = kk[127 - 8 * i -: 8];
            st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        end
        for (int i = 4; i < 44; i++)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = rk[4 * (i - 1) + j];
            if ((i % 4) == 0)
            begin
                f = t[0];
                t[0] = sub_byte(t[1]) ^ rc;
                t[1] = sub_byte(t[2]);
                t[2] = sub_byte(t[3]);
                t[3] = sub_byte(f);
                rc = dbl(rc);
            end
            for (int j = 0; j < 4; j++)
                rk[4 * i + j] = rk[4 * (i - 4) + j] ^ t[j];
        end
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    sh[j + 4 * c] = sub_byte(st[j + 4 * ((c + j) % 4)]);
            if (r < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = sh[4 * c];
                    a1 = sh[4 * c + 1];
                    a2 = sh[4 * c + 2];
                    a3 = sh[4 * c + 3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    sh[4 * c]     = a0 ^ al ^ dbl(a0 ^ a1);
                    sh[4 * c + 1] = a1 ^ al ^ dbl(a1 ^ a2);
                    sh[4 * c + 2] = a2 ^ al ^ dbl(a2 ^ a3);
                    sh[4 * c + 3] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] = sh[i] ^ rk[16 * r + i];
        end
        for (int i = 0; i < 16; i++)
            ct[127 - 8 * i -: 8] = st[i];
        return ct;
    endfunction

    // flags, nonce from the stored header, 16-bit length or block index
    function automatic logic [127:0] nonce_block(input logic [7:0] flags, input logic [7:0] tail);
        logic [31:0] cnt;
        if (hdr_bytes[0][3])
            cnt = {hdr_bytes[3], hdr_bytes[4], hdr_bytes[5], hdr_bytes[6]};
        else
            cnt = {8'd0, hdr_bytes[3], hdr_bytes[4], hdr_bytes[5]};
        return {flags, hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], cnt, 48'd0, 8'd0, tail};
    endfunction

    function automatic void expect_byte(input logic [7:0] b, input logic l, input logic [1:0] s);
        out_t o;
        o.out_byte = b;
        o.last = l;
        o.status = s;
        expected_bytes.push_back(o);
    endfunction

    function automatic void close_frame();
        for (int i = 0; i < TAG_BYTES; i++)
            expect_byte(mac_acc[127 - 8 * i -: 8] ^ tag_pad[127 - 8 * i -: 8], 1'b0, ST_OK);
        frame_open = 1'b0;
        expect_byte({hop_budget, 4'd0}, 1'b1, ST_OK);
    endfunction

    function automatic void encode_item(input in_t it);
        logic [7:0] hlen;
        logic       wide;
        logic [3:0] p;
        logic [7:0] c;
        if (it.func == 1'b0)
        begin
            wide = it.counter > 32'h00FF_FFFF;
            hlen = wide ? 8'd7 : 8'd6;
            frame_open = 1'b0;
            discarding = 1'b0;
            if (it.body_length > MAX_BODY
                || 32'(hlen) + 32'(it.body_length) + TAG_BYTES + 1 > 32'(buf_limit))
            begin
                discarding = it.body_length != 0;
                remaining = it.body_length;
                expect_byte(8'd0, 1'b1, it.body_length > MAX_BODY ? ST_LONG : ST_SIZE);
                return;
            end
            hdr_bytes[0] = {it.version, it.msg_type, wide, 3'b000};
            hdr_bytes[1] = it.source;
            hdr_bytes[2] = it.destination;
            if (wide)
                {hdr_bytes[3], hdr_bytes[4], hdr_bytes[5], hdr_bytes[6]} = it.counter;
            else
                {hdr_bytes[3], hdr_bytes[4], hdr_bytes[5]} = it.counter[23:0];
            hop_budget = it.budget;
            remaining = it.body_length;
            ctr_block = 8'd1;
            blk_pos = '0;
            mac_acc = aes_encrypt(nonce_block(B0_FLAGS, it.body_length));
            mac_acc[119:112] ^= hlen;
            for (int i = 0; i < hlen; i++)
                mac_acc[111 - 8 * i -: 8] ^= hdr_bytes[i];
            mac_acc = aes_encrypt(mac_acc);
            tag_pad = aes_encrypt(nonce_block(A_FLAGS, 8'd0));
            for (int i = 0; i < hlen; i++)
                expect_byte(hdr_bytes[i], 1'b0, ST_OK);
            frame_open = 1'b1;
            if (it.body_length == 0)
                close_frame();
            return;
        end
        if (discarding)
        begin
            if (remaining > 0)
                remaining--;
            if (remaining == 0)
                discarding = 1'b0;
            return;
        end
        if (!frame_open)
            return;
        p = blk_pos;
        if (p == 0)
            key_stream = aes_encrypt(nonce_block(A_FLAGS, ctr_block));
        mac_acc[127 - 8 * p -: 8] ^= it.body_byte;
        c = it.body_byte ^ key_stream[127 - 8 * p -: 8];
        expect_byte(c, 1'b0, ST_OK);
        remaining--;
        if (p == 4'd15 || remaining == 0)
        begin
            mac_acc = aes_encrypt(mac_acc);
            ctr_block++;
            blk_pos = '0;
        end
        else
            blk_pos = p + 4'd1;
        if (remaining == 0)
            close_frame();
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                encode_item(item);
                void'(frame_items.pop_front());
                void'(wait_drain.pop_front());
                if ($urandom_range(0, 63) == 0)
                    send_bursty = !send_bursty;
                send_gap = send_bursty ? $urandom_range(0, 6) : 0;
            end
            if (push && full)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (frame_items.size() > 0
                     && !(wait_drain[0] && expected_bytes.size() > 0))
            begin
                push <= 1'b1;
                item <= frame_items[0];
            end
            else
                push <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected result transaction: out_byte %0h", result.out_byte);
                    errors++;
                end
                else
                begin
                    if (result.out_byte !== expected_bytes[0].out_byte)
                    begin
                        $error("out_byte: expected %0h, got %0h",
                               expected_bytes[0].out_byte, result.out_byte);
                        errors++;
                    end
                    if (result.last !== expected_bytes[0].last)
                    begin
                        $error("last: expected %0b, got %0b",
                               expected_bytes[0].last, result.last);
                        errors++;
                    end
                    if (result.status !== expected_bytes[0].status)
                    begin
                        $error("status: expected %0d, got %0d",
                               expected_bytes[0].status, result.status);
                        errors++;
                    end
                    void'(expected_bytes.pop_front());
                end
                if ($urandom_range(0, 63) == 0)
                    recv_bursty = !recv_bursty;
                recv_gap = recv_bursty ? $urandom_range(0, 6) : 0;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    function automatic void add_item(input in_t it, input bit hold);
        frame_items.push_back(it);
        wait_drain.push_back(hold);
    endfunction

    function automatic in_t random_item();
        in_t it;
        it = in_t'($bits(in_t)'({$urandom, $urandom, $urandom}));
        return it;
    endfunction

    function automatic void add_header(input int len, input logic [31:0] cnt, input bit hold);
        in_t it;
        it = random_item();
        it.func = 1'b0;
        it.counter = cnt;
        it.body_length = 8'(len);
        add_item(it, hold);
    endfunction

    function automatic void add_body(input int n);
        in_t it;
        for (int i = 0; i < n; i++)
        begin
            it = random_item();
            it.func = 1'b1;
            add_item(it, 1'b0);
        end
    endfunction

    function automatic logic [31:0] random_counter();
        case ($urandom_range(0, 4))
            0: return 32'h00FF_FFFF - $urandom_range(0, 2);
            1: return 32'h0100_0000 + $urandom_range(0, 2);
            2: return $urandom;
            default: return $urandom_range(0, 32'h00FF_FFFF);
        endcase
    endfunction

    function automatic void random_frames(input int count, input bit with_pause);
        int n;
        int len;
        int r;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 128) : $urandom_range(0, 40);
            if (r < 70)
            begin
                add_header(len, random_counter(), with_pause && n > count / 2);
                with_pause = with_pause && n <= count / 2;
                add_body(len);
                n += len + 1;
            end
            else if (r < 78)
            begin
                len = $urandom_range(1, 40);
                add_header(len, random_counter(), 1'b0);
                add_body($urandom_range(0, len - 1));
                n += 1;
            end
            else if (r < 86)
            begin
                len = $urandom_range(129, 255);
                add_header(len, random_counter(), 1'b0);
                add_body($urandom_range(0, 3) == 0 ? $urandom_range(0, len - 1) : len);
                n += 1;
            end
            else if (r < 91)
                add_body($urandom_range(1, 3));
            else
            begin
                len = $urandom_range(0, 2) == 0 ? 0 : int'(buf_limit) - $urandom_range(9, 13);
                if (len < 0)
                    len = 0;
                add_header(len, random_counter(), 1'b0);
                add_body(len);
                n += len + 1;
            end
        end
    endfunction

    task automatic settle();
        while (frame_items.size() > 0 || push || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_KEY_HIGH)
            key_hi = val;
        else if (idx == REG_KEY_LOW)
            key_lo = val;
        else if (idx == REG_BUF_SIZE)
            buf_limit = val[7:0];
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset keys: short directed frames
        add_header(0, 32'd0, 1'b0);
        add_body(2);                                  // no frame open
        add_header(3, 32'h00FF_FFFF, 1'b0);
        add_body(3);
        settle();

        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
        write_reg(REG_KEY_LOW, {$urandom, $urandom});
        add_header(128, 32'h0100_0000, 1'b0);        // longest body, wide counter
        add_body(128);
        add_header(129, 32'hFFFF_FFFF, 1'b0);        // body too long, then dropped
        add_body(129);
        add_header(255, 32'h0, 1'b0);
        add_body(5);
        add_header(17, 32'h0000_0001, 1'b0);         // abandoned by next header
        add_body(16);
        add_header(16, 32'h00FF_FFFF, 1'b1);         // sender waits for all results first
        add_body(16);
        settle();

        write_reg(REG_BUF_SIZE, 8'd11);              // 6-byte header + 5 fits, 7-byte does not
        add_header(0, 32'h0000_1234, 1'b0);
        add_header(0, 32'h1234_5678, 1'b0);
        add_header(1, 32'h0000_0000, 1'b0);
        add_body(1);
        settle();

        write_reg(REG_BUF_SIZE, 8'd255);
        random_frames(60, 1'b1);
        settle();

        write_reg(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_BUF_SIZE, 8'($urandom_range(12, 60)));
        random_frames(30, 1'b0);
        settle();

        write_reg(REG_BUF_SIZE, 8'd0);
        add_header(0, 32'd5, 1'b0);
        add_header(4, 32'd6, 1'b0);
        add_body(4);
        settle();

        write_reg(REG_KEY_HIGH, 64'd0);
        write_reg(REG_KEY_LOW, {$urandom, $urandom});
        write_reg(REG_BUF_SIZE, 8'd255);
        random_frames(30, 1'b0);
        settle();

        if (errors == 0)
            $display("[ccm_secured_frame_encoder_unit] OK");
        else
            $display("[ccm_secured_frame_encoder_unit] ERROR");
        $finish;
    end

    initial begin
        #30ms;
        $display("[ccm_secured_frame_encoder_unit] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
